// ===== src/stok_pkg.sv =====
// Types, character codes and token decode functions for the shell command tokenizer.
`default_nettype none

package stok_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_WORD    = 4'd1,
    M_WESC    = 4'd2,
    M_WDOLLAR = 4'd3,
    M_WGROUP  = 4'd4,
    M_SQ      = 4'd5,
    M_DQ      = 4'd6,
    M_DQESC   = 4'd7,
    M_PIPE    = 4'd8,
    M_AMP     = 4'd9,
    M_GT      = 4'd10,
    M_LT1     = 4'd11,
    M_LT2     = 4'd12,
    M_DRAIN   = 4'd13
  } lex_mode_e;

  typedef enum logic [3:0] {
    K_END     = 4'd0,
    K_WORD    = 4'd1,
    K_STRING  = 4'd2,
    K_PIPE    = 4'd3,
    K_AND     = 4'd4,
    K_OR      = 4'd5,
    K_SEMI    = 4'd6,
    K_OUT     = 4'd7,
    K_APPEND  = 4'd8,
    K_IN      = 4'd9,
    K_HEREDOC = 4'd10,
    K_HERESTR = 4'd11,
    K_LBRACE  = 4'd12,
    K_RBRACE  = 4'd13,
    K_LPAREN  = 4'd14,
    K_RPAREN  = 4'd15
  } tok_kind_e;

  typedef enum logic [1:0] {
    E_NONE  = 2'd0,
    E_SQ    = 2'd1,
    E_DQ    = 2'd2,
    E_BGND  = 2'd3
  } tok_err_e;

  // One output word.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       token_done;
    logic [3:0] kind;
    logic [1:0] err;
  } res_t;

  // Outcome of one input byte: next mode and up to three words.
  typedef struct packed {
    lex_mode_e  mode;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } step_t;

  function automatic res_t mk_text(logic [7:0] b);
    res_t r;
    r.text_byte  = b;
    r.text_valid = 1'b1;
    r.token_done = 1'b0;
    r.kind       = K_END;
    r.err        = E_NONE;
    return r;
  endfunction

  function automatic res_t mk_tok(tok_kind_e k, tok_err_e e);
    res_t r;
    r.text_byte  = 8'h00;
    r.text_valid = 1'b0;
    r.token_done = 1'b1;
    r.kind       = k;
    r.err        = e;
    return r;
  endfunction

  function automatic step_t push(step_t s, res_t r);
    step_t t;
    t = s;
    case (s.n)
      2'd0:    t.r0 = r;
      2'd1:    t.r1 = r;
      default: t.r2 = r;
    endcase
    t.n = s.n + 2'd1;
    return t;
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return (c == CH_NUL) || (c == CH_LF);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    logic d;
    case (c)
      CH_NUL, CH_LF, CH_SPACE, CH_TAB, CH_PIPE, CH_AMP, CH_SEMI, CH_GT, CH_LT,
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_DQUOTE, CH_SQUOTE: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  // Bareword byte that is known not to be a delimiter.
  function automatic step_t word_plain(step_t s, logic [7:0] c);
    step_t t;
    t = s;
    if (c == CH_BSLASH) begin
      t.mode = M_WESC;
    end else if (c == CH_DOLLAR) begin
      t = push(t, mk_text(c));
      t.mode = M_WDOLLAR;
    end else begin
      t = push(t, mk_text(c));
      t.mode = M_WORD;
    end
    return t;
  endfunction

  function automatic step_t idle_fn(step_t s, logic [7:0] c);
    step_t t;
    t = s;
    t.mode = M_IDLE;
    case (c)
      CH_NUL, CH_LF:    t = push(t, mk_tok(K_END, E_NONE));
      CH_SPACE, CH_TAB: t = t;
      CH_PIPE:          t.mode = M_PIPE;
      CH_AMP:           t.mode = M_AMP;
      CH_GT:            t.mode = M_GT;
      CH_LT:            t.mode = M_LT1;
      CH_SEMI:          t = push(t, mk_tok(K_SEMI, E_NONE));
      CH_LPAREN:        t = push(t, mk_tok(K_LPAREN, E_NONE));
      CH_RPAREN:        t = push(t, mk_tok(K_RPAREN, E_NONE));
      CH_LBRACE:        t = push(t, mk_tok(K_LBRACE, E_NONE));
      CH_RBRACE:        t = push(t, mk_tok(K_RBRACE, E_NONE));
      CH_SQUOTE:        t.mode = M_SQ;
      CH_DQUOTE:        t.mode = M_DQ;
      default:          t = word_plain(t, c);
    endcase
    return t;
  endfunction

  function automatic step_t word_fn(step_t s, logic [7:0] c);
    step_t t;
    t = s;
    if (is_delim(c)) begin
      t = push(t, mk_tok(K_WORD, E_NONE));
      t = idle_fn(t, c);
    end else begin
      t = word_plain(t, c);
    end
    return t;
  endfunction

  function automatic step_t dq_fn(step_t s, logic [7:0] c);
    step_t t;
    t = s;
    t.mode = M_DQ;
    if (c == CH_NUL) begin
      t = push(t, mk_tok(K_END, E_DQ));
      t.mode = M_IDLE;
    end else if (c == CH_DQUOTE) begin
      t = push(t, mk_tok(K_STRING, E_NONE));
      t.mode = M_IDLE;
    end else if (c == CH_BSLASH) begin
      t.mode = M_DQESC;
    end else begin
      t = push(t, mk_text(c));
    end
    return t;
  endfunction

  function automatic step_t op_or_idle(step_t s, logic [7:0] c, logic [7:0] match,
                                       tok_kind_e k_match, tok_kind_e k_else);
    step_t t;
    t = s;
    if (c == match) begin
      t = push(t, mk_tok(k_match, E_NONE));
      t.mode = M_IDLE;
    end else begin
      t = push(t, mk_tok(k_else, E_NONE));
      t = idle_fn(t, c);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/shell_command_tokenizer.sv =====
// Byte-stream shell command tokenizer with a three-word output buffer.
// Latency: the first word of a byte is shown in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one word and the
// output is ready; for a byte with more words, input waits until the last one leaves.
// Bytes that yield no word are taken every cycle while the buffer is empty.
// Reset: the lexer returns to idle between tokens and the output buffer is emptied.
`default_nettype none

module shell_command_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      text_byte_o,
  output logic            text_valid_o,
  output logic            token_done_o,
  output logic [3:0]      token_kind_o,
  output logic [1:0]      error_code_o,
  output logic            last_o
);
  import stok_pkg::*;

  lex_mode_e  mode_q, mode_d;
  logic [1:0] cnt_q, cnt_d;
  res_t       slot0_q, slot1_q, slot2_q;
  res_t       slot0_d, slot1_d, slot2_d;
  step_t      base, step;
  logic       accept, pop;

  assign pop        = out_valid_o && out_ready_i;
  // A new byte may enter when the buffer is empty or its final word leaves now.
  assign in_ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    base      = '0;
    base.mode = mode_q;
    step      = base;
    unique case (mode_q)
      M_WORD: step = word_fn(base, char_in_i);
      M_WESC: begin
        if (char_in_i == CH_NUL) begin
          step = push(base, mk_text(CH_BSLASH));
          step = push(step, mk_tok(K_WORD, E_NONE));
          step = push(step, mk_tok(K_END, E_NONE));
          step.mode = M_IDLE;
        end else begin
          step = push(base, mk_text(char_in_i));
          step.mode = M_WORD;
        end
      end
      M_WDOLLAR: begin
        if (char_in_i == CH_LBRACE) begin
          step = push(base, mk_text(char_in_i));
          step.mode = M_WGROUP;
        end else begin
          step = word_fn(base, char_in_i);
        end
      end
      M_WGROUP: begin
        if (char_in_i == CH_NUL) begin
          step = push(base, mk_tok(K_WORD, E_NONE));
          step = push(step, mk_tok(K_END, E_NONE));
          step.mode = M_IDLE;
        end else begin
          step = push(base, mk_text(char_in_i));
          if (char_in_i == CH_RBRACE) step.mode = M_WORD;
        end
      end
      M_SQ: begin
        if (char_in_i == CH_NUL) begin
          step = push(base, mk_tok(K_END, E_SQ));
          step.mode = M_IDLE;
        end else if (char_in_i == CH_SQUOTE) begin
          step = push(base, mk_tok(K_WORD, E_NONE));
          step.mode = M_IDLE;
        end else begin
          step = push(base, mk_text(char_in_i));
        end
      end
      M_DQ: step = dq_fn(base, char_in_i);
      M_DQESC: begin
        if ((char_in_i == CH_DQUOTE) || (char_in_i == CH_BSLASH) ||
            (char_in_i == CH_DOLLAR)) begin
          step = push(base, mk_text(char_in_i));
          step.mode = M_DQ;
        end else begin
          step = push(base, mk_text(CH_BSLASH));
          step = dq_fn(step, char_in_i);
        end
      end
      M_PIPE: step = op_or_idle(base, char_in_i, CH_PIPE, K_OR, K_PIPE);
      M_AMP: begin
        if (char_in_i == CH_AMP) begin
          step = push(base, mk_tok(K_AND, E_NONE));
          step.mode = M_IDLE;
        end else if (is_term(char_in_i)) begin
          step = push(base, mk_tok(K_END, E_BGND));
          step.mode = M_IDLE;
        end else begin
          step.mode = M_DRAIN;
        end
      end
      M_GT: step = op_or_idle(base, char_in_i, CH_GT, K_APPEND, K_OUT);
      M_LT1: begin
        if (char_in_i == CH_LT) begin
          step.mode = M_LT2;
        end else begin
          step = push(base, mk_tok(K_IN, E_NONE));
          step = idle_fn(step, char_in_i);
        end
      end
      M_LT2: step = op_or_idle(base, char_in_i, CH_LT, K_HERESTR, K_HEREDOC);
      M_DRAIN: begin
        if (is_term(char_in_i)) begin
          step = push(base, mk_tok(K_END, E_BGND));
          step.mode = M_IDLE;
        end
      end
      default: step = idle_fn(base, char_in_i);
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    slot2_d = slot2_q;
    if (accept) begin
      mode_d  = step.mode;
      cnt_d   = step.n;
      slot0_d = step.r0;
      slot1_d = step.r1;
      slot2_d = step.r2;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
      slot1_d = slot2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
    slot2_q <= slot2_d;
  end

  assign out_valid_o  = (cnt_q != 2'd0);
  assign text_byte_o  = slot0_q.text_byte;
  assign text_valid_o = slot0_q.text_valid;
  assign token_done_o = slot0_q.token_done;
  assign token_kind_o = slot0_q.kind;
  assign error_code_o = slot0_q.err;
  assign last_o       = (cnt_q == 2'd1);

  a_text_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (text_valid_o != token_done_o))
    else $error("output word is neither text nor token, or both");

  a_err_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != E_NONE)) |-> (token_done_o && (token_kind_o == K_END)))
    else $error("error code on a word other than an end token");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q <= 2'd1))
    else $error("input taken while the buffer still holds several words");

  a_silent_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (step.n == 2'd0)) |=> !out_valid_o)
    else $error("a byte without results left words in the buffer");

endmodule

`default_nettype wire

// ===== tb/tb_shell_command_tokenizer.sv =====
// Self-checking testbench for the shell command tokenizer with token prediction.
`timescale 1ns / 1ps

module tb_shell_command_tokenizer;
  import stok_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 310;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       token_done;
    logic [3:0] kind;
    logic [1:0] err;
    logic       last;
  } tok_word_t;

  class token_scoreboard;
    lex_mode_e   mode;
    tok_word_t   pending_words[$];
    tok_word_t   byte_words[$];
    int unsigned errors;

    function new();
      mode = M_IDLE;
      errors = 0;
    endfunction

    function void emit(logic [7:0] b, logic tv, logic td, tok_kind_e k, tok_err_e e);
      tok_word_t w;
      w.text_byte  = b;
      w.text_valid = tv;
      w.token_done = td;
      w.kind       = k;
      w.err        = e;
      w.last       = 1'b0;
      byte_words.push_back(w);
    endfunction

    function void emit_text(logic [7:0] b);
      emit(b, 1'b1, 1'b0, K_END, E_NONE);
    endfunction

    function void emit_token(tok_kind_e k, tok_err_e e);
      emit(8'h00, 1'b0, 1'b1, k, e);
    endfunction

    function bit breaks_word(logic [7:0] c);
      case (c)
        CH_NUL, CH_LF, CH_SPACE, CH_TAB, CH_PIPE, CH_AMP, CH_SEMI, CH_GT, CH_LT,
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_DQUOTE, CH_SQUOTE: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Byte that cannot end a bareword.
    function void word_text(logic [7:0] c);
      if (c == CH_BSLASH) begin
        mode = M_WESC;
      end else if (c == CH_DOLLAR) begin
        emit_text(c);
        mode = M_WDOLLAR;
      end else begin
        emit_text(c);
        mode = M_WORD;
      end
    endfunction

    function void start_token(logic [7:0] c);
      mode = M_IDLE;
      case (c)
        CH_NUL, CH_LF: emit_token(K_END, E_NONE);
        CH_SPACE, CH_TAB: begin
        end
        CH_PIPE:   mode = M_PIPE;
        CH_AMP:    mode = M_AMP;
        CH_GT:     mode = M_GT;
        CH_LT:     mode = M_LT1;
        CH_SEMI:   emit_token(K_SEMI, E_NONE);
        CH_LPAREN: emit_token(K_LPAREN, E_NONE);
        CH_RPAREN: emit_token(K_RPAREN, E_NONE);
        CH_LBRACE: emit_token(K_LBRACE, E_NONE);
        CH_RBRACE: emit_token(K_RBRACE, E_NONE);
        CH_SQUOTE: mode = M_SQ;
        CH_DQUOTE: mode = M_DQ;
        default:   word_text(c);
      endcase
    endfunction

    function void word_next(logic [7:0] c);
      if (breaks_word(c)) begin
        emit_token(K_WORD, E_NONE);
        start_token(c);
      end else begin
        word_text(c);
      end
    endfunction

    function void dquote_next(logic [7:0] c);
      mode = M_DQ;
      if (c == CH_NUL) begin
        emit_token(K_END, E_DQ);
        mode = M_IDLE;
      end else if (c == CH_DQUOTE) begin
        emit_token(K_STRING, E_NONE);
        mode = M_IDLE;
      end else if (c == CH_BSLASH) begin
        mode = M_DQESC;
      end else begin
        emit_text(c);
      end
    endfunction

    // Next byte of a possible longer operator (||, >>, <<<).
    function void pair_op(logic [7:0] c, logic [7:0] second, tok_kind_e k_pair,
                          tok_kind_e k_single);
      if (c == second) begin
        emit_token(k_pair, E_NONE);
        mode = M_IDLE;
      end else begin
        emit_token(k_single, E_NONE);
        start_token(c);
      end
    endfunction

    function void note_byte(logic [7:0] c);
      tok_word_t w;
      byte_words.delete();
      case (mode)
        M_WORD: word_next(c);
        M_WESC: begin
          if (c == CH_NUL) begin
            emit_text(CH_BSLASH);
            emit_token(K_WORD, E_NONE);
            emit_token(K_END, E_NONE);
            mode = M_IDLE;
          end else begin
            emit_text(c);
            mode = M_WORD;
          end
        end
        M_WDOLLAR: begin
          if (c == CH_LBRACE) begin
            emit_text(c);
            mode = M_WGROUP;
          end else begin
            word_next(c);
          end
        end
        M_WGROUP: begin
          if (c == CH_NUL) begin
            emit_token(K_WORD, E_NONE);
            emit_token(K_END, E_NONE);
            mode = M_IDLE;
          end else begin
            emit_text(c);
            if (c == CH_RBRACE) mode = M_WORD;
          end
        end
        M_SQ: begin
          if (c == CH_NUL) begin
            emit_token(K_END, E_SQ);
            mode = M_IDLE;
          end else if (c == CH_SQUOTE) begin
            emit_token(K_WORD, E_NONE);
            mode = M_IDLE;
          end else begin
            emit_text(c);
          end
        end
        M_DQ: dquote_next(c);
        M_DQESC: begin
          if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR) begin
            emit_text(c);
            mode = M_DQ;
          end else begin
            emit_text(CH_BSLASH);
            dquote_next(c);
          end
        end
        M_PIPE: pair_op(c, CH_PIPE, K_OR, K_PIPE);
        M_AMP: begin
          if (c == CH_AMP) begin
            emit_token(K_AND, E_NONE);
            mode = M_IDLE;
          end else if (c == CH_NUL || c == CH_LF) begin
            emit_token(K_END, E_BGND);
            mode = M_IDLE;
          end else begin
            mode = M_DRAIN;
          end
        end
        M_GT: pair_op(c, CH_GT, K_APPEND, K_OUT);
        M_LT1: begin
          if (c == CH_LT) begin
            mode = M_LT2;
          end else begin
            emit_token(K_IN, E_NONE);
            start_token(c);
          end
        end
        M_LT2: pair_op(c, CH_LT, K_HERESTR, K_HEREDOC);
        M_DRAIN: begin
          if (c == CH_NUL || c == CH_LF) begin
            emit_token(K_END, E_BGND);
            mode = M_IDLE;
          end
        end
        default: start_token(c);
      endcase
      if (byte_words.size() > 0) begin
        w = byte_words.pop_back();
        w.last = 1'b1;
        byte_words.push_back(w);
      end
      foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_word(tok_word_t got);
      tok_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual text %0h/%0b done %0b kind %0d",
                 $time, got.text_byte, got.text_valid, got.token_done, got.kind);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.text_byte !== want.text_byte) report("text_byte", want.text_byte, got.text_byte);
      if (got.text_valid !== want.text_valid)
        report("text_valid", want.text_valid, got.text_valid);
      if (got.token_done !== want.token_done)
        report("token_done", want.token_done, got.token_done);
      if (got.kind !== want.kind) report("token_kind", want.kind, got.kind);
      if (got.err !== want.err) report("error_code", want.err, got.err);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_in_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] text_byte_o;
  logic       text_valid_o;
  logic       token_done_o;
  logic [3:0] token_kind_o;
  logic [1:0] error_code_o;
  logic       last_o;

  token_scoreboard sb;
  bit              idle_on = 1'b1;
  int              items_sent = 0;
  int              quiet_cycles = 0;
  tok_word_t       seen;
  string           op_text[13] = '{"|", "||", "&&", ";", ">", ">>", "<", "<<", "<<<",
                                   "(", ")", "{", "}"};

  shell_command_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_byte_o (text_byte_o),
    .text_valid_o(text_valid_o),
    .token_done_o(token_done_o),
    .token_kind_o(token_kind_o),
    .error_code_o(error_code_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both channels are sampled at the edge, before any register update of that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && in_ready_o) begin
        sb.note_byte(char_in_i);
        quiet_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        seen.text_byte  = text_byte_o;
        seen.text_valid = text_valid_o;
        seen.token_done = token_done_o;
        seen.kind       = token_kind_o;
        seen.err        = error_code_o;
        seen.last       = last_o;
        sb.check_word(seen);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      out_ready_i <= !(idle_on && $urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] any_but(logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == x);
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (sb.breaks_word(c) || c == CH_BSLASH || c == CH_DOLLAR);
    return c;
  endfunction

  task automatic send_fragment();
    case ($urandom_range(0, 9))
      0, 1: begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 7))
            0: begin
              send_byte(CH_BSLASH);
              send_byte(8'($urandom_range(0, 255)));
            end
            1: begin
              send_byte(CH_DOLLAR);
              if ($urandom_range(0, 1)) begin
                send_byte(CH_LBRACE);
                repeat ($urandom_range(0, 3)) send_byte(any_but(CH_RBRACE));
                send_byte(CH_RBRACE);
              end
            end
            default: send_byte(plain_char());
          endcase
        end
      end
      2: begin
        send_byte(CH_SQUOTE);
        repeat ($urandom_range(0, 5)) send_byte(any_but(CH_SQUOTE));
        send_byte(CH_SQUOTE);
      end
      3: begin
        send_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_BSLASH);
            case ($urandom_range(0, 3))
              0:       send_byte(CH_DQUOTE);
              1:       send_byte(CH_BSLASH);
              2:       send_byte(CH_DOLLAR);
              default: send_byte(any_but(CH_NUL));
            endcase
          end else begin
            send_byte(any_but(CH_DQUOTE));
          end
        end
        send_byte(CH_DQUOTE);
      end
      4, 5: send_text(op_text[$urandom_range(0, 12)]);
      6: send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      7: send_byte(8'($urandom_range(0, 255)));
      8: begin
        // Broken constructs: open quotes or group cut by a zero byte, or a lone ampersand.
        case ($urandom_range(0, 3))
          0: begin
            send_byte(CH_SQUOTE);
            repeat ($urandom_range(0, 3)) send_byte(any_but(CH_SQUOTE));
            send_byte(CH_NUL);
          end
          1: begin
            send_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 3)) send_byte(any_but(CH_DQUOTE));
            send_byte(CH_NUL);
          end
          2: begin
            send_byte(CH_AMP);
            repeat ($urandom_range(0, 3)) send_byte(any_but(CH_LF));
            send_byte($urandom_range(0, 1) ? CH_NUL : CH_LF);
          end
          default: begin
            send_byte(plain_char());
            send_text("${");
            repeat ($urandom_range(0, 3)) send_byte(any_but(CH_RBRACE));
            send_byte(CH_NUL);
          end
        endcase
      end
      default: begin
        send_byte(plain_char());
        send_byte(CH_SPACE);
      end
    endcase
  endtask

  initial begin
    int random_start;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every operator, then the quoting, escape and error cases.
    send_byte(CH_NUL);
    send_text("|||;&&>>>(<<<<<)<{}\t\n");
    send_text("'a\n'$b\\\n${\n}\"\\\"\\\\\\$\\q");
    send_byte(8'hff);
    send_text("\n\"b\\");
    send_byte(CH_NUL);
    send_text("&x y\n&\n'z");
    send_byte(CH_NUL);
    send_byte(CH_DQUOTE);
    send_byte(CH_NUL);

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      idle_on = (items_sent < random_start + RANDOM_ITEMS - 80);
      repeat ($urandom_range(1, 6)) send_fragment();
      send_byte($urandom_range(0, 1) ? CH_NUL : CH_LF);
    end
    send_byte(CH_NUL);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== shell_command_tokenizer.f =====
src/stok_pkg.sv
src/shell_command_tokenizer.sv
tb/tb_shell_command_tokenizer.sv
